>>> design/sjn_pkg.sv
// sjn_pkg: shared commands and chain control type for the shortest-job-next scheduler
// no dependencies
package sjn_pkg;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_ARRIVE = 1'b1;

    typedef struct packed {
        logic insert;
        logic pop;
    } sjn_chain_ctl_t;

endpackage

>>> design/sjn_cell.sv
// sjn_cell: one slot of the sorted ready chain, holds one waiting job
// depends on sjn_pkg
module sjn_cell
    import sjn_pkg::*;
#(
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sjn_chain_ctl_t       ctl,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic [TIME_BITS-1:0] new_time,
    input  logic                 prev_valid,
    input  logic [ID_BITS-1:0]   prev_id,
    input  logic [TIME_BITS-1:0] prev_time,
    input  logic                 prev_cond,
    input  logic                 next_valid,
    input  logic [ID_BITS-1:0]   next_id,
    input  logic [TIME_BITS-1:0] next_time,
    output logic                 valid,
    output logic [ID_BITS-1:0]   id,
    output logic [TIME_BITS-1:0] job_time,
    output logic                 cond
);

    logic                 valid_reg, valid_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [TIME_BITS-1:0] time_reg, time_next;

    // new job goes ahead of this entry: empty slot or not shorter than the new one
    assign cond = !valid_reg || (new_time <= time_reg);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        if (ctl.pop)
        begin
            valid_next = next_valid;
            id_next    = next_id;
            time_next  = next_time;
        end
        else if (ctl.insert)
        begin
            if (prev_cond)
            begin
                valid_next = prev_valid;
                id_next    = prev_id;
                time_next  = prev_time;
            end
            else if (cond)
            begin
                valid_next = 1'b1;
                id_next    = new_id;
                time_next  = new_time;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign valid    = valid_reg;
    assign id       = id_reg;
    assign job_time = time_reg;

endmodule

>>> design/sjn_chain.sv
// sjn_chain: row of sjn_cell slots kept sorted by time, newest first among equals
// depends on sjn_pkg and sjn_cell
module sjn_chain
    import sjn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int TIME_BITS   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sjn_chain_ctl_t       ctl,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic [TIME_BITS-1:0] new_time,
    output logic [ID_BITS-1:0]   head_id,
    output logic [TIME_BITS-1:0] head_time
);

    logic                 valid_w [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   id_w    [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] time_w  [QUEUE_DEPTH];
    logic                 cond_w  [QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                 p_valid;
            logic [ID_BITS-1:0]   p_id;
            logic [TIME_BITS-1:0] p_time;
            logic                 p_cond;
            logic                 n_valid;
            logic [ID_BITS-1:0]   n_id;
            logic [TIME_BITS-1:0] n_time;

            if (i == 0)
            begin : g_first
                assign p_valid = 1'b0;
                assign p_id    = '0;
                assign p_time  = '0;
                assign p_cond  = 1'b0;
            end
            else
            begin : g_mid
                assign p_valid = valid_w[i-1];
                assign p_id    = id_w[i-1];
                assign p_time  = time_w[i-1];
                assign p_cond  = cond_w[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign n_valid = 1'b0;
                assign n_id    = '0;
                assign n_time  = '0;
            end
            else
            begin : g_body
                assign n_valid = valid_w[i+1];
                assign n_id    = id_w[i+1];
                assign n_time  = time_w[i+1];
            end

            sjn_cell #(
                .ID_BITS   (ID_BITS),
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_id     (new_id),
                .new_time   (new_time),
                .prev_valid (p_valid),
                .prev_id    (p_id),
                .prev_time  (p_time),
                .prev_cond  (p_cond),
                .next_valid (n_valid),
                .next_id    (n_id),
                .next_time  (n_time),
                .valid      (valid_w[i]),
                .id         (id_w[i]),
                .job_time   (time_w[i]),
                .cond       (cond_w[i])
            );
        end
    endgenerate

    assign head_id   = id_w[0];
    assign head_time = time_w[0];

endmodule

>>> design/shortest_job_next_scheduler.sv
// shortest_job_next_scheduler: non-preemptive shortest-job-next scheduler top level
// depends on sjn_pkg and sjn_chain
//
// usage
//   input channel in_valid/in_stall carries command, job_id, job_time;
//   command CMD_TICK advances the scheduler, CMD_ARRIVE brings a new job
//   output channel out_valid/out_stall carries one result item per input item:
//   running slot status, queue count and the drop flag of a full-queue arrival
// timing
//   an item is captured in the input register and then executed, where the
//   sorted chain inserts or pops in one step and the result register is loaded;
//   the result is valid after the item executes, and no new item is accepted
//   until then; in_stall is high while a captured item waits to execute
// stall
//   while out_stall holds a result, the next captured item waits in the input
//   register, so nothing is lost and the result stays stable
// reset
//   rst_n clears the running slot, the queue count, all chain valid bits and
//   both handshakes; no clearing pass is needed
module shortest_job_next_scheduler
    import sjn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int TIME_BITS   = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [ID_BITS-1:0]                  job_id,
    input  logic [TIME_BITS-1:0]                job_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                running_valid,
    output logic [ID_BITS-1:0]                  running_id,
    output logic [TIME_BITS-1:0]                running_time_left,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]  queued_count,
    output logic                                arrival_dropped
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic                 busy_reg;
    logic                 cmd_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] time_reg;

    logic                 run_valid_reg, run_valid_next;
    logic [ID_BITS-1:0]   run_id_reg, run_id_next;
    logic [TIME_BITS-1:0] run_time_reg, run_time_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    logic                 out_valid_reg;
    logic                 o_valid_reg;
    logic [ID_BITS-1:0]   o_id_reg;
    logic [TIME_BITS-1:0] o_time_reg;
    logic [CNT_BITS-1:0]  o_count_reg;
    logic                 o_drop_reg;

    logic                 accept;
    logic                 exec;
    logic                 dropped;
    logic                 pick_valid;
    logic [ID_BITS-1:0]   pick_id;
    logic [TIME_BITS-1:0] pick_time;
    logic [ID_BITS-1:0]   head_id;
    logic [TIME_BITS-1:0] head_time;
    sjn_chain_ctl_t       ctl;

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign exec     = busy_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_time_next  = run_time_reg;
        count_next     = count_reg;
        dropped        = 1'b0;
        ctl            = '{insert: 1'b0, pop: 1'b0};
        pick_valid     = run_valid_reg;
        pick_id        = run_id_reg;
        pick_time      = run_time_reg;
        if (cmd_reg == CMD_ARRIVE)
        begin
            if (!run_valid_reg)
            begin
                run_valid_next = 1'b1;
                run_id_next    = id_reg;
                run_time_next  = time_reg;
            end
            else if (count_reg < CNT_BITS'(QUEUE_DEPTH))
            begin
                ctl.insert = 1'b1;
                count_next = count_reg + CNT_BITS'(1);
            end
            else
            begin
                dropped = 1'b1;
            end
        end
        else
        begin
            if (!run_valid_reg || (run_time_reg == '0))
            begin
                if (count_reg != '0)
                begin
                    ctl.pop    = 1'b1;
                    count_next = count_reg - CNT_BITS'(1);
                    pick_valid = 1'b1;
                    pick_id    = head_id;
                    pick_time  = head_time;
                end
                else
                begin
                    pick_valid = 1'b0;
                    pick_id    = '0;
                    pick_time  = '0;
                end
            end
            run_valid_next = pick_valid;
            run_id_next    = pick_id;
            run_time_next  = (pick_valid && (pick_time != '0)) ?
                             pick_time - TIME_BITS'(1) : pick_time;
        end
        if (!exec)
        begin
            ctl = '{insert: 1'b0, pop: 1'b0};
        end
    end

    sjn_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_id    (id_reg),
        .new_time  (time_reg),
        .head_id   (head_id),
        .head_time (head_time)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_time_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end
            if (exec)
            begin
                run_valid_reg <= run_valid_next;
                run_id_reg    <= run_id_next;
                run_time_reg  <= run_time_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            id_reg   <= job_id;
            time_reg <= job_time;
        end
        if (exec)
        begin
            o_valid_reg <= run_valid_next;
            o_id_reg    <= run_valid_next ? run_id_next : '0;
            o_time_reg  <= run_valid_next ? run_time_next : '0;
            o_count_reg <= count_next;
            o_drop_reg  <= dropped;
        end
    end

    assign out_valid         = out_valid_reg;
    assign running_valid     = o_valid_reg;
    assign running_id        = o_id_reg;
    assign running_time_left = o_time_reg;
    assign queued_count      = o_count_reg;
    assign arrival_dropped   = o_drop_reg;

endmodule
